// File: src/dsog_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsog_pkg
// shared constants and types for the occupancy grid core
// ----------------------------------------------------------------------------
package dsog_pkg;

  localparam int GRID_SIDE  = 64;
  localparam int MAX_REACH  = 4;
  localparam int NODE_BITS  = 16;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int BOX_MAX    = 4 * MAX_REACH * MAX_REACH;
  localparam int LIST_W     = $clog2(BOX_MAX + 1);
  localparam int LIST_AW    = $clog2(BOX_MAX);

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_CELL_EDGE = 3'd2;
  localparam logic [2:0] REG_LAST_COL  = 3'd3;
  localparam logic [2:0] REG_LAST_ROW  = 3'd4;

  localparam logic OP_TAG   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REACH,
    ST_BOX,
    ST_RD,
    ST_MUL,
    ST_SQ,
    ST_DEC,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

// File: src/disk_sampling_occupancy_grid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_sampling_occupancy_grid_core
// poisson-disk background grid: tag cells around a point, query neighbors
// ----------------------------------------------------------------------------
// After reset a clearing pass writes zero to all 4096 cells, one per cycle;
// no transaction is accepted during the clearing pass. Each transaction then
// passes an accept state, the reach (a bit-serial divide of radius by
// cell_edge, one quotient bit per cycle; the largest reach when cell_edge is
// zero), a box setup state and per box cell the steps memory read, corner
// multiply, squaring and decision/writeback, up to 64 cells. A query stores the
// owner of every non-empty box cell in a small list memory, then per result
// runs one scan over the stored entries that finds the smallest node number
// above the previous one, and presents it until out_ready takes it; each
// result is an output transaction gated by out_ready. One transaction is in
// flight at a time.
module disk_sampling_occupancy_grid_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_opcode,
  input  logic [5:0]                     in_cell_col,
  input  logic [5:0]                     in_cell_row,
  input  logic signed [31:0]             in_pos_x,
  input  logic signed [31:0]             in_pos_y,
  input  logic [31:0]                    in_excl_radius,
  input  logic [15:0]                    in_node_tag,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    out_node_id,
  output logic                           out_found,
  output logic                           out_last
);
  import dsog_pkg::*;

  // configuration
  logic signed [31:0] origin_x_r, origin_y_r;
  logic [31:0] cell_edge_r;
  logic [5:0]  last_col_r, last_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      cell_edge_r <= 32'd65536;
      last_col_r <= 6'd63;
      last_row_r <= 6'd63;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:  origin_x_r  <= cfg_data;
        REG_ORIGIN_Y:  origin_y_r  <= cfg_data;
        REG_CELL_EDGE: cell_edge_r <= cfg_data;
        REG_LAST_COL:  last_col_r  <= cfg_data[5:0];
        REG_LAST_ROW:  last_row_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // grid memory
  logic [NODE_BITS-1:0] mem [CELL_COUNT];
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa, mem_ra;
  logic [NODE_BITS-1:0] mem_wd, mem_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[mem_ra];
  end

  // transaction registers
  state_t state_r, state_nxt;
  logic        op_r;
  logic [5:0]  col_r, row_r;
  logic signed [31:0] px_r, py_r;
  logic [15:0] tag_r;
  logic [ADDR_W:0] clr_r;
  // reach divide: n = radius + edge - 1 (33 bits), restoring division
  logic [32:0] dnum_r;
  logic [32:0] drem_r;
  logic [5:0]  dcnt_r;
  logic [2:0]  reach_r;
  logic [6:0]  i_r, i1_r, j_r, j0_r, j1_r;
  logic [6:0]  stride_w;
  logic [ADDR_W:0] idx_full;
  // corner math
  logic [32:0] ax_r, ay_r;
  logic        far_r;
  logic [63:0] dx2_r, dy2_r, r2_r;
  logic [NODE_BITS-1:0] v_r;
  // owners seen by a query, unsorted, duplicates kept
  logic [NODE_BITS-1:0] lmem [BOX_MAX];
  logic                 lmem_we;
  logic [LIST_AW-1:0]   lmem_wa, lmem_ra;
  logic [NODE_BITS-1:0] lmem_rd_r;
  logic [LIST_W-1:0]    cnt_r, sk_r;
  // smallest and second smallest node above the last one sent
  logic [NODE_BITS-1:0] base_r, m1_r, m2_r;
  logic                 m1v_r, m2v_r;

  always_ff @(posedge clk) begin
    if (lmem_we) lmem[lmem_wa] <= v_r;
    lmem_rd_r <= lmem[lmem_ra];
  end

  assign stride_w = (last_row_r == 6'd63) ? 7'd64 : {1'b0, last_row_r} + 7'd1;
  assign idx_full = (ADDR_W+1)'(i_r * stride_w + {6'd0, j_r});

  logic div_sub_ok;
  logic [33:0] div_trial;
  assign div_trial = {drem_r, dnum_r[32]} - {2'b0, cell_edge_r};
  assign div_sub_ok = !div_trial[33];

  // half-open box, clamped to the grid edges
  logic [6:0] xe_w, ye_w, ti_w, tj_w, i0_w, j0_w, i1_w, j1_w;
  logic       box_empty_w, cell_last_w, tag_hit_w, sc_gt_w;

  assign xe_w = {1'b0, last_col_r} + 7'd1;
  assign ye_w = {1'b0, last_row_r} + 7'd1;
  assign ti_w = {1'b0, col_r} + {4'd0, reach_r};
  assign tj_w = {1'b0, row_r} + {4'd0, reach_r};
  assign i0_w = (col_r > {3'd0, reach_r}) ? {1'b0, col_r} - {4'd0, reach_r} : 7'd0;
  assign j0_w = (row_r > {3'd0, reach_r}) ? {1'b0, row_r} - {4'd0, reach_r} : 7'd0;
  assign i1_w = (ti_w < xe_w) ? ti_w : xe_w;
  assign j1_w = (tj_w < ye_w) ? tj_w : ye_w;
  assign box_empty_w = (i0_w >= i1_w) || (j0_w >= j1_w);
  assign cell_last_w = (j_r + 7'd1 >= j1_r) && (i_r + 7'd1 >= i1_r);
  assign tag_hit_w   = !far_r && dx2_r < r2_r && dy2_r < r2_r - dx2_r;
  assign sc_gt_w     = (lmem_rd_r > base_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == (ADDR_W+1)'(CELL_COUNT - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_REACH;
      ST_REACH: if (cell_edge_r == '0 || dcnt_r == 6'd33) state_nxt = ST_BOX;
      ST_BOX: begin
        if (box_empty_w) state_nxt = (op_r == OP_QUERY) ? ST_SCAN : ST_IDLE;
        else state_nxt = ST_RD;
      end
      ST_RD:    state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SQ;
      ST_SQ:    state_nxt = ST_DEC;
      ST_DEC: begin
        if (cell_last_w) state_nxt = (op_r == OP_QUERY) ? ST_SCAN : ST_IDLE;
        else state_nxt = ST_RD;
      end
      ST_SCAN:  if (sk_r == cnt_r) state_nxt = ST_EMIT;
      ST_EMIT:  if (out_ready) state_nxt = m2v_r ? ST_SCAN : ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = (state_r == ST_EMIT);
  assign out_found   = m1v_r;
  assign out_node_id = m1v_r ? m1_r : '0;
  // nothing above the current node means this is the final result
  assign out_last    = !m2v_r;

  // corner coordinate (i * edge fits 39 bits)
  logic signed [40:0] cx_w, cy_w, dxs_w, dys_w;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_r[ADDR_W-1:0];
    mem_wd = '0;
    mem_ra = idx_full[ADDR_W-1:0];
    if (state_r == ST_CLEAR) mem_we = 1'b1;
    else if (state_r == ST_DEC && op_r == OP_TAG && !idx_full[ADDR_W] &&
             mem_rd_r == '0 && tag_hit_w) begin
      mem_we = 1'b1;
      mem_wa = idx_full[ADDR_W-1:0];
      mem_wd = tag_r;
    end
  end

  assign lmem_we = (state_r == ST_DEC) && (op_r == OP_QUERY) && !idx_full[ADDR_W] &&
                   (v_r != '0);
  assign lmem_wa = cnt_r[LIST_AW-1:0];
  assign lmem_ra = sk_r[LIST_AW-1:0];

  assign cx_w = 41'(origin_x_r) + $signed({2'b0, 39'(i_r) * 39'(cell_edge_r)});
  assign cy_w = 41'(origin_y_r) + $signed({2'b0, 39'(j_r) * 39'(cell_edge_r)});
  assign dxs_w = 41'(px_r) - cx_w;
  assign dys_w = 41'(py_r) - cy_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      cnt_r <= '0;
      sk_r <= '0;
      m1v_r <= 1'b0;
      m2v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_CLEAR: clr_r <= clr_r + 1'b1;
        ST_IDLE: if (in_valid) begin
          op_r <= in_opcode; col_r <= in_cell_col; row_r <= in_cell_row;
          px_r <= in_pos_x; py_r <= in_pos_y;
          tag_r <= in_node_tag;
          dnum_r <= {1'b0, in_excl_radius} + {1'b0, cell_edge_r} - 33'd1;
          drem_r <= '0; dcnt_r <= '0; reach_r <= '0;
          cnt_r <= '0; base_r <= '0;
          r2_r <= 64'(in_excl_radius) * 64'(in_excl_radius);
        end
        ST_REACH: begin
          if (cell_edge_r == '0) reach_r <= 3'(MAX_REACH);
          else if (dcnt_r != 6'd33) begin
            drem_r <= div_sub_ok ? div_trial[32:0] : {drem_r[31:0], dnum_r[32]};
            dnum_r <= {dnum_r[31:0], div_sub_ok};
            dcnt_r <= dcnt_r + 6'd1;
          end else begin
            // dnum_r now holds quotient
            reach_r <= (dnum_r > 33'(MAX_REACH)) ? 3'(MAX_REACH) : dnum_r[2:0];
          end
        end
        ST_BOX: begin
          i_r  <= i0_w;
          j_r  <= j0_w;
          j0_r <= j0_w;
          i1_r <= i1_w;
          j1_r <= j1_w;
        end
        ST_RD: begin
          ax_r <= dxs_w[40] ? 33'(-dxs_w) : 33'(dxs_w);
          ay_r <= dys_w[40] ? 33'(-dys_w) : 33'(dys_w);
          far_r <= (dxs_w > 41'sh0FFFFFFFF) || (dxs_w < -41'sh0FFFFFFFF) ||
                   (dys_w > 41'sh0FFFFFFFF) || (dys_w < -41'sh0FFFFFFFF);
        end
        ST_MUL: begin
          dx2_r <= 64'(ax_r[31:0]) * 64'(ax_r[31:0]);
          v_r <= mem_rd_r;
        end
        ST_SQ: dy2_r <= 64'(ay_r[31:0]) * 64'(ay_r[31:0]);
        ST_DEC: begin
          if (lmem_we) cnt_r <= cnt_r + LIST_W'(1);
          if (j_r + 7'd1 >= j1_r) begin
            j_r <= j0_r; i_r <= i_r + 7'd1;
          end else j_r <= j_r + 7'd1;
        end
        ST_SCAN: begin
          // entry sk_r-1 arrives from the list memory this cycle
          if (sk_r != '0 && sc_gt_w) begin
            if (!m1v_r || lmem_rd_r < m1_r) begin
              m2_r <= m1_r; m2v_r <= m1v_r;
              m1_r <= lmem_rd_r; m1v_r <= 1'b1;
            end else if (lmem_rd_r != m1_r && (!m2v_r || lmem_rd_r < m2_r)) begin
              m2_r <= lmem_rd_r; m2v_r <= 1'b1;
            end
          end
          if (sk_r != cnt_r) sk_r <= sk_r + LIST_W'(1);
        end
        ST_EMIT: if (out_ready) base_r <= m1_r;
        default: ;
      endcase
      // fresh scan for the next result
      if (state_nxt == ST_SCAN && state_r != ST_SCAN) begin
        sk_r <= '0;
        m1v_r <= 1'b0;
        m2v_r <= 1'b0;
      end
    end
  end
endmodule

// File: src/dsog_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsog_checker
// port-level checks for the occupancy grid core
// ----------------------------------------------------------------------------
module dsog_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_found,
  input logic out_last,
  input logic [15:0] out_node_id
);
  // no new input while results are pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready during results");
  // empty result is final
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last && out_node_id == '0)
    else $error("empty result not final");
  // found results carry nonzero id
  a_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_node_id != '0) else $error("zero id");
  // results held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("dropped result");
endmodule

bind disk_sampling_occupancy_grid_core dsog_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
  .out_last(out_last), .out_node_id(out_node_id)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the poisson-disk occupancy grid core
// ----------------------------------------------------------------------------
// Tag and query transactions are driven over valid/ready in random bursts.
// A scoreboard keeps its own copy of the cell store and the grid registers,
// predicts the neighbor list of every query and checks each result
// transaction in order. Grid registers change between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;
  import dsog_pkg::*;

  typedef struct {
    logic               op;
    logic [5:0]         col;
    logic [5:0]         row;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0]        rad;
    logic [15:0]        tag;
  } grid_op_t;

  typedef struct {
    logic [15:0] node;
    logic        found;
    logic        last;
  } hit_t;

  // scoreboard: private copy of the grid plus the queue of pending neighbors
  class grid_scoreboard;
    logic [15:0]        owner[CELL_COUNT];
    logic signed [31:0] org_x, org_y;
    logic [31:0]        edge_len;
    logic [5:0]         col_max, row_max;
    hit_t               expected_hits[$];

    function new();
      foreach (owner[k]) owner[k] = '0;
      org_x = 0; org_y = 0; edge_len = 32'd65536;
      col_max = 6'd63; row_max = 6'd63;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_ORIGIN_X:  org_x = val;
        REG_ORIGIN_Y:  org_y = val;
        REG_CELL_EDGE: edge_len = val;
        REG_LAST_COL:  col_max = val[5:0];
        REG_LAST_ROW:  row_max = val[5:0];
        default: ;
      endcase
    endfunction

    function int reach_of(logic [31:0] rad);
      longint unsigned n;
      if (edge_len == 0) return MAX_REACH;
      n = (64'(rad) + 64'(edge_len) - 1) / 64'(edge_len);
      return (n > MAX_REACH) ? MAX_REACH : int'(n);
    endfunction

    // exact squared-distance test of the cell corner against the radius
    function bit corner_in(grid_op_t t, int i, int j);
      longint cx, cy;
      longint unsigned ax, ay, r2, dx2, dy2;
      cx = longint'(org_x) + longint'(i) * longint'({32'b0, edge_len});
      cy = longint'(org_y) + longint'(j) * longint'({32'b0, edge_len});
      ax = (longint'(t.px) >= cx) ? longint'(t.px) - cx : cx - longint'(t.px);
      ay = (longint'(t.py) >= cy) ? longint'(t.py) - cy : cy - longint'(t.py);
      r2 = 64'(t.rad) * 64'(t.rad);
      if (ax > 64'hFFFF_FFFF || ay > 64'hFFFF_FFFF) return 0;
      dx2 = ax * ax;
      dy2 = ay * ay;
      if (dx2 >= r2) return 0;
      return dy2 < r2 - dx2;
    endfunction

    // accepted input transaction: update the grid or queue the neighbor list
    function void note_item(grid_op_t t);
      int reach, xe, ye, i0, i1, j0, j1, idx;
      logic [15:0] ids[$];
      hit_t h;
      reach = reach_of(t.rad);
      xe = int'(col_max) + 1;
      ye = int'(row_max) + 1;
      i0 = (t.col > reach) ? int'(t.col) - reach : 0;
      i1 = (int'(t.col) + reach < xe) ? int'(t.col) + reach : xe;
      j0 = (t.row > reach) ? int'(t.row) - reach : 0;
      j1 = (int'(t.row) + reach < ye) ? int'(t.row) + reach : ye;
      for (int i = i0; i < i1; i++)
        for (int j = j0; j < j1; j++) begin
          idx = i * ye + j;
          if (t.op == OP_TAG) begin
            if (owner[idx] == 0 && corner_in(t, i, j)) owner[idx] = t.tag;
          end else if (owner[idx] != 0) begin
            bit dup;
            dup = 0;
            foreach (ids[k]) if (ids[k] == owner[idx]) dup = 1;
            if (!dup) ids = {ids, owner[idx]};
          end
        end
      if (t.op == OP_TAG) return;
      if (ids.size() == 0) begin
        h.node = '0; h.found = 0; h.last = 1;
        expected_hits = {expected_hits, h};
        return;
      end
      ids.sort();
      foreach (ids[k]) begin
        h.node = ids[k]; h.found = 1; h.last = (k == ids.size() - 1);
        expected_hits = {expected_hits, h};
      end
    endfunction

    // returns an empty string when the result matches the oldest expectation
    function string check_hit(hit_t got);
      hit_t w;
      if (expected_hits.size() == 0)
        return $sformatf("unexpected result node=%0d found=%0b last=%0b",
                         got.node, got.found, got.last);
      w = expected_hits.pop_front();
      if (got.node !== w.node || got.found !== w.found || got.last !== w.last)
        return $sformatf("result node=%0d found=%0b last=%0b, wanted %0d %0b %0b",
                         got.node, got.found, got.last, w.node, w.found, w.last);
      return "";
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid, in_ready;
  logic               in_opcode;
  logic [5:0]         in_cell_col, in_cell_row;
  logic signed [31:0] in_pos_x, in_pos_y;
  logic [31:0]        in_excl_radius;
  logic [15:0]        in_node_tag;
  logic               out_valid, out_ready;
  logic [15:0]        out_node_id;
  logic               out_found, out_last;

  grid_scoreboard sb;
  int unsigned    err_count, items_sent, queries_sent, results_seen;
  // sender idling
  bit             idle_on;
  int             burst_left;
  // receiver stalls: mode, pattern, and long hold-off requests
  bit             stall_on;
  logic [7:0]     stall_pat;
  int             pat_pos, hold_cnt, hold_ask, hold_seen;

  disk_sampling_occupancy_grid_core dut (.*);

  // 10 ns clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // result side: check accepted results, then drive out_ready for next edge
  initial begin
    string msg;
    hit_t  got;
    out_ready <= 1'b0;
    hold_cnt = 0; hold_seen = 0; pat_pos = 0; stall_pat = 8'hFF;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.node = out_node_id; got.found = out_found; got.last = out_last;
        results_seen++;
        msg = sb.check_hit(got);
        if (msg != "") report(msg);
      end
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_cnt  = 600;
      end
      pat_pos = (pat_pos + 1) % 8;
      if (pat_pos == 0) stall_pat = 8'($urandom);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (stall_on) begin
        out_ready <= stall_pat[pat_pos];
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // wait for all results, then for any tag still walking its box
  task automatic drain();
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] e,
                          logic [5:0] lc, logic [5:0] lr);
    drain();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_CELL_EDGE, e);
    write_reg(REG_LAST_COL, {26'b0, lc});
    write_reg(REG_LAST_ROW, {26'b0, lr});
    cfg_we <= 1'b0;
  endtask

  // offer one transaction; valid stays up into the next one inside a burst
  task automatic send(grid_op_t t);
    int gap;
    in_valid       <= 1'b1;
    in_opcode      <= t.op;
    in_cell_col    <= t.col;
    in_cell_row    <= t.row;
    in_pos_x       <= t.px;
    in_pos_y       <= t.py;
    in_excl_radius <= t.rad;
    in_node_tag    <= t.tag;
    do @(posedge clk); while (!in_ready);
    sb.note_item(t);
    items_sent++;
    if (t.op == OP_QUERY) queries_sent++;
    if (!idle_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = int'($urandom_range(0, 7));
    gap = int'($urandom_range(1, 12));
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  function automatic grid_op_t mk(logic op, int col, int row, logic [31:0] px,
                                  logic [31:0] py, logic [31:0] rad,
                                  logic [15:0] tag);
    grid_op_t t;
    t.op = op; t.col = col[5:0]; t.row = row[5:0];
    t.px = px; t.py = py; t.rad = rad; t.tag = tag;
    return t;
  endfunction

  // mostly well-placed points with random content, some pure noise
  function automatic grid_op_t rand_op();
    grid_op_t t;
    longint   e;
    e = (sb.edge_len == 0) ? 64'd65536 : longint'({32'b0, sb.edge_len});
    if ($urandom_range(0, 99) < 12) begin
      t = mk(1'($urandom), int'($urandom), int'($urandom), $urandom, $urandom,
             $urandom, 16'($urandom));
      return t;
    end
    t.op  = ($urandom_range(0, 99) < 55) ? OP_TAG : OP_QUERY;
    t.col = 6'($urandom_range(0, sb.col_max));
    t.row = 6'($urandom_range(0, sb.row_max));
    t.px  = 32'(longint'(sb.org_x) + longint'(t.col) * e + longint'($urandom) % e);
    t.py  = 32'(longint'(sb.org_y) + longint'(t.row) * e + longint'($urandom) % e);
    t.rad = 32'(longint'($urandom_range(0, 4)) * e + longint'($urandom) % e);
    t.tag = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 24));
    return t;
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      send(rand_op());
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int wait_cnt;
    sb = new();
    err_count = 0; items_sent = 0; queries_sent = 0; results_seen = 0;
    hold_ask = 0; burst_left = 0; idle_on = 0; stall_on = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    in_valid <= 1'b0; in_opcode <= OP_TAG; in_cell_col <= '0; in_cell_row <= '0;
    in_pos_x <= '0; in_pos_y <= '0; in_excl_radius <= '0; in_node_tag <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on the reset grid, unit cell edge
    send(mk(OP_QUERY, 5, 5, 32'h0005_8000, 32'h0005_8000, 32'h0003_0000, 0));  // empty grid
    send(mk(OP_TAG, 5, 5, 32'h0005_8000, 32'h0005_8000, 32'h0002_0000, 7));
    send(mk(OP_TAG, 8, 8, 32'h0008_0000, 32'h0008_0000, 32'h0000_0000, 9));    // zero radius
    send(mk(OP_TAG, 20, 20, 32'h0014_4000, 32'h0014_4000, 32'h0002_0000, 0));  // zero tag
    send(mk(OP_TAG, 0, 0, 32'h0000_0000, 32'h0000_0000, 32'h0004_0000, 16'hFFFF));
    send(mk(OP_TAG, 63, 63, 32'h003F_8000, 32'h003F_8000, 32'hFFFF_FFFF, 3));
    send(mk(OP_TAG, 6, 6, 32'h0006_3333, 32'h0006_3333, 32'h0001_8000, 2));
    send(mk(OP_TAG, 30, 30, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 11));
    send(mk(OP_TAG, 40, 10, 32'h0028_1000, 32'h000A_F000, 32'h0000_0001, 5));
    send(mk(OP_QUERY, 5, 5, 0, 0, 32'h0003_0000, 0));
    send(mk(OP_QUERY, 6, 6, 0, 0, 32'h0004_0000, 0));
    send(mk(OP_QUERY, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
    send(mk(OP_QUERY, 63, 63, 0, 0, 32'hFFFF_FFFF, 0));
    send(mk(OP_QUERY, 20, 20, 0, 0, 32'h0002_0000, 0));
    send(mk(OP_QUERY, 40, 40, 0, 0, 32'h0000_0000, 0));                        // empty box
    send(mk(OP_QUERY, 30, 30, 0, 0, 32'h0001_0000, 0));
    in_valid <= 1'b0;

    // small grid, half cell, negative origin; includes points beyond the edge
    set_grid(32'hFFF0_0000, 32'hFFFF_8000, 32'h0000_8000, 6'd15, 6'd9);
    send(mk(OP_TAG, 40, 3, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 4));
    send(mk(OP_QUERY, 40, 3, 0, 0, 32'h0001_0000, 0));
    random_phase(15);

    // extreme registers: largest edge and spread origins
    set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd1, 6'd63);
    random_phase(20);

    // degenerate grid: zero edge, one column, one row
    set_grid(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 6'd0, 6'd0);
    random_phase(10);
    set_grid(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 6'd63, 6'd1);
    random_phase(10);

    // back to a full grid; long receiver hold-off while queries keep coming
    set_grid(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 6'd63, 6'd63);
    random_phase(15);
    idle_on = 0;
    stall_on = 0;
    hold_ask++;
    for (int k = 0; k < 6; k++)
      send(mk(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 63), 0, 0,
              32'h0004_0000, 0));
    in_valid <= 1'b0;
    random_phase(10);

    wait_cnt = 0;
    while (sb.expected_hits.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (400) @(posedge clk);
    if (sb.expected_hits.size() != 0) report("results still outstanding at end of run");

    $display("covered %0d transactions (%0d queries), %0d results checked",
             items_sent, queries_sent, results_seen);
    $display("grid settings: reset, small offset, extreme edge, zero edge, unit grid");
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
